@@ rtl/core/fpe_pkg.sv @@
package fpe_pkg;

  localparam int MAX_FRAGS      = 128;
  localparam int MAX_FRAG_BYTES = 64;
  localparam int ADDR_W         = 13;
  localparam int X_W            = 27;
  localparam int SEED_STEP      = 1001;

  localparam logic CFG_FRAG_COUNT = 1'b0;
  localparam logic CFG_FRAG_BYTES = 1'b1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [12:0] load_address;
    logic [7:0]  load_byte;
    logic [15:0] parity_index;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [5:0] byte_position;
    logic       last;
  } out_t;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_STEP    = 7'b0000010,
    ST_MODGO   = 7'b0000100,
    ST_MODWAIT = 7'b0001000,
    ST_CHECK   = 7'b0010000,
    ST_XRD     = 7'b0100000,
    ST_XDRAIN  = 7'b1000000
  } state_t;

endpackage

@@ rtl/core/fpe_mod.sv @@
module fpe_mod
  import fpe_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [X_W-1:0] dividend,
  input  logic [7:0]     modulus,
  output logic           done,
  output logic [7:0]     rem
);

  logic           busy_r;
  logic [4:0]     cnt_r;
  logic [X_W-1:0] x_r;
  logic [7:0]     rem_r;
  logic           done_r;
  logic [8:0]     shifted;
  logic [8:0]     reduced;

  always_comb begin
    shifted = {rem_r, x_r[X_W-1]};
    reduced = (shifted >= {1'b0, modulus}) ? shifted - {1'b0, modulus} : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(X_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[X_W-2:0], 1'b0};
      rem_r <= reduced[7:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/fragment_parity_encoder.sv @@
// Channel  Ports                              Direction
// input    start, busy, in_data (in_t)        in, handshake out
// result   out_valid, out_data (out_t)        out, one-cycle strobe
// config   cfg_we, cfg_index, cfg_data        in, write only
//
// A load item is written to the store when it is accepted. An encode item
// first builds the row with a shared bit-serial remainder unit, one PRBS step
// at a time, for m/2 accepted values, then XORs the store at one read per
// cycle for each output byte. Reset is synchronous and active low; the store is
// not cleared. Results cannot be stalled.
module fragment_parity_encoder
  import fpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_t        in_data,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [7:0]       frag_count_r;
  logic [6:0]       frag_bytes_r;
  logic [7:0]       m_r, m_nxt;
  logic [6:0]       fb_r, fb_nxt;
  logic [7:0]       mod_r, mod_nxt;
  logic [X_W-1:0]   x_r, x_nxt;
  logic [MAX_FRAGS-1:0] mask_r, mask_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [7:0]       frag_i_r, frag_i_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [5:0]       byte_r, byte_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic             rd_en;
  logic             rd_vld_r;
  logic [7:0]       rd_data_r;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;
  logic             mod_start;
  logic             mod_done;
  logic [7:0]       mod_rem;
  logic             accept;
  logic [7:0]       m_sel;
  logic [6:0]       fb_sel;
  logic             fbk;

  logic [7:0] store_mem [0:(1 << ADDR_W)-1];

  fpe_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (x_r),
    .modulus  (mod_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    m_sel  = (frag_count_r > 8'(MAX_FRAGS)) ? 8'(MAX_FRAGS) : frag_count_r;
    fb_sel = (frag_bytes_r == '0) ? 7'd1 :
             (frag_bytes_r > 7'(MAX_FRAG_BYTES)) ? 7'(MAX_FRAG_BYTES) : frag_bytes_r;
    fbk    = x_r[0] ^ x_r[5];
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    fb_nxt        = fb_r;
    mod_nxt       = mod_r;
    x_nxt         = x_r;
    mask_nxt      = mask_r;
    cnt_nxt       = cnt_r;
    frag_i_nxt    = frag_i_r;
    addr_nxt      = addr_r;
    byte_nxt      = byte_r;
    acc_nxt       = rd_vld_r ? (acc_r ^ rd_data_r) : acc_r;
    rd_en         = 1'b0;
    mod_start     = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.action == ACT_ENCODE) begin
          m_nxt    = m_sel;
          fb_nxt   = fb_sel;
          mod_nxt  = (m_sel != '0 && (m_sel & (m_sel - 8'd1)) == '0) ?
                     m_sel + 8'd1 : m_sel;
          x_nxt    = X_W'(SEED_STEP) * ({11'd0, in_data.parity_index} + X_W'(1))
                     + X_W'(1);
          mask_nxt = '0;
          cnt_nxt  = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (cnt_r == m_r[7:1]) begin
          frag_i_nxt = '0;
          addr_nxt   = '0;
          byte_nxt   = '0;
          acc_nxt    = '0;
          state_nxt  = ST_XRD;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        x_nxt     = (x_r >> 1) + (X_W'(fbk) << 22);
        state_nxt = ST_MODGO;
      end
      ST_MODGO: begin
        mod_start = 1'b1;
        state_nxt = ST_MODWAIT;
      end
      ST_MODWAIT: begin
        if (mod_done) begin
          if (mod_rem < m_r) begin
            mask_nxt[mod_rem[6:0]] = 1'b1;
            cnt_nxt   = cnt_r + 7'd1;
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_XRD: begin
        if (frag_i_r < m_r) begin
          rd_en      = mask_r[frag_i_r[6:0]];
          frag_i_nxt = frag_i_r + 8'd1;
          addr_nxt   = addr_r + ADDR_W'(fb_r);
        end else begin
          state_nxt = ST_XDRAIN;
        end
      end
      ST_XDRAIN: begin
        out_valid_nxt         = 1'b1;
        out_nxt.out_byte      = acc_r;
        out_nxt.byte_position = byte_r;
        out_nxt.last          = ({1'b0, byte_r} + 7'd1 == fb_r);
        acc_nxt    = '0;
        frag_i_nxt = '0;
        byte_nxt   = byte_r + 6'd1;
        addr_nxt   = ADDR_W'(byte_r) + ADDR_W'(1);
        state_nxt  = out_nxt.last ? ST_IDLE : ST_XRD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frag_count_r <= 8'd128;
      frag_bytes_r <= 7'd64;
      out_valid_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
      mask_r       <= '0;
      cnt_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_en;
      mask_r      <= mask_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_FRAG_COUNT) begin
          frag_count_r <= cfg_data;
        end else begin
          frag_bytes_r <= cfg_data[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    fb_r     <= fb_nxt;
    mod_r    <= mod_nxt;
    x_r      <= x_nxt;
    frag_i_r <= frag_i_nxt;
    addr_r   <= addr_nxt;
    byte_r   <= byte_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.action == ACT_LOAD) begin
      store_mem[in_data.load_address] <= in_data.load_byte;
    end
    rd_data_r <= store_mem[addr_r];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ bench/fragment_parity_checker.sv @@
module fragment_parity_checker
  import fpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  in_t        in_data,
  input  logic       out_valid,
  input  out_t       out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         bytes_seen
);

  logic [7:0]  frag_store [0:MAX_FRAGS*MAX_FRAG_BYTES-1];
  logic [7:0]  frag_count_reg;
  logic [6:0]  frag_bytes_reg;
  logic [31:0] prbs_state;
  out_t        parity_queue [$];

  function automatic logic [31:0] prbs_advance(input logic [31:0] v);
    logic [31:0] fbk;
    fbk = {31'd0, v[0] ^ v[5]};
    return (v >> 1) + (fbk << 22);
  endfunction

  task automatic predict_parity(input logic [15:0] index);
    logic [MAX_FRAGS-1:0] row;
    int unsigned m, fb, modulus, x, r, k, b, i;
    logic [7:0] acc;
    out_t res;
    m = (frag_count_reg > MAX_FRAGS) ? MAX_FRAGS : frag_count_reg;
    fb = (frag_bytes_reg == 0) ? 1 : frag_bytes_reg;
    if (fb > MAX_FRAG_BYTES) fb = MAX_FRAG_BYTES;
    modulus = (m != 0 && (m & (m - 1)) == 0) ? m + 1 : m;
    x = 1 + SEED_STEP * (index + 1);
    row = '0;
    for (k = 0; k < (m >> 1); k++) begin
      r = 1 << 16;
      while (r >= m) begin
        x = prbs_advance(x);
        r = x % modulus;
      end
      row[r] = 1'b1;
    end
    prbs_state = x;
    for (b = 0; b < fb; b++) begin
      acc = '0;
      for (i = 0; i < m; i++)
        if (row[i]) acc ^= frag_store[i * fb + b];
      res.out_byte = acc;
      res.byte_position = b[5:0];
      res.last = (b + 1 == fb);
      parity_queue.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      frag_count_reg <= 8'd128;
      frag_bytes_reg <= 7'd64;
      prbs_state = '0;
      parity_queue.delete();
      fail_count <= 0;
      bytes_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FRAG_COUNT) frag_count_reg <= cfg_data;
        else frag_bytes_reg <= cfg_data[6:0];
      end
      if (start && !busy) begin
        if (in_data.action == ACT_LOAD) frag_store[in_data.load_address] = in_data.load_byte;
        else predict_parity(in_data.parity_index);
      end
      if (out_valid) begin
        bytes_seen <= bytes_seen + 1;
        if (parity_queue.size() == 0) begin
          $error("parity byte with nothing expected: %p", out_data);
          errs++;
        end else begin
          want = parity_queue.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h actual %0h", want.out_byte, out_data.out_byte);
            errs++;
          end
          if (out_data.byte_position !== want.byte_position) begin
            $error("byte_position expected %0d actual %0d", want.byte_position,
                   out_data.byte_position);
            errs++;
          end
          if (out_data.last !== want.last) begin
            $error("last expected %0b actual %0b", want.last, out_data.last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= parity_queue.size();
    end
  end

endmodule

@@ bench/fragment_parity_encoder_test.sv @@
module fragment_parity_encoder_test;
  import fpe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_t        in_data = '0;
  logic       out_valid;
  out_t       out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_FRAG_COUNT;
  logic [7:0] cfg_data = '0;
  int         fail_count, pending, bytes_seen;
  int         cycles = 0;
  int         encodes = 0;
  int         loads = 0;

  fragment_parity_encoder dut (.*);

  fragment_parity_checker checker_i (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input in_t item);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_data = item;
    do @(posedge clk); while (busy);
    if (item.action == ACT_ENCODE) encodes++;
    else loads++;
    @(negedge clk);
  endtask

  task automatic send_encode(input logic [15:0] index);
    in_t item;
    item = in_t'({$urandom, $urandom});
    item.action = ACT_ENCODE;
    item.parity_index = index;
    send_item(item);
  endtask

  task automatic send_random(input int count, input int encode_pct);
    in_t item;
    repeat (count) begin
      item = in_t'({$urandom, $urandom});
      if ($urandom_range(0, 99) < encode_pct) begin
        item.action = ACT_ENCODE;
        if ($urandom_range(0, 7) == 0) item.parity_index = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
      end else begin
        item.action = ACT_LOAD;
      end
      send_item(item);
    end
  endtask

  task automatic settle_and_configure(input logic [7:0] count, input logic [7:0] size);
    start = 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_FRAG_COUNT;
    cfg_data = count;
    @(negedge clk);
    cfg_index = CFG_FRAG_BYTES;
    cfg_data = size;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    in_t item;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    // The first 128 store entries are written before the first encode, and every
    // setting below keeps the fragments it reads inside them.
    for (int a = 0; a < 128; a++) begin
      item = in_t'({$urandom, $urandom});
      item.action = ACT_LOAD;
      item.load_address = a[12:0];
      if (a < 4) item.load_byte = a[0] ? 8'hFF : 8'h00;
      send_item(item);
    end
    settle_and_configure(8'd255, 8'd0);
    send_encode(16'd0);
    send_encode(16'hFFFF);
    settle_and_configure(8'd0, 8'd0);
    send_encode(16'd5);
    settle_and_configure(8'd1, 8'd127);
    send_encode(16'd7);
    settle_and_configure(8'd2, 8'd127);
    send_encode(16'd0);
    send_encode(16'hFFFF);
    settle_and_configure(8'd16, 8'd8);
    send_random(3, 70);
    settle_and_configure(8'd37, 8'd3);
    send_random(3, 70);
    settle_and_configure(8'd5, 8'd3);
    send_random(2, 70);
    settle_and_configure(8'd64, 8'd2);
    send_random(2, 70);
    settle_and_configure(8'd3, 8'd13);
    send_random(2, 70);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Ran %0d encodes and %0d loads over fragment counts 0..255 and sizes 0..127,",
             encodes, loads);
    $display("checking %0d parity bytes.", bytes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
